[src/unix_time_to_calendar_with_dst_macros.svh]
// Assertion macros for the Unix time to calendar converter.
`ifndef UNIX_TIME_TO_CALENDAR_WITH_DST_MACROS_SVH
`define UNIX_TIME_TO_CALENDAR_WITH_DST_MACROS_SVH

// same-cycle implication
`define UTCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utcd assertion failed");

// next-cycle implication
`define UTCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utcd assertion failed");

`endif

[src/utcd_pkg.sv]
// Shared types, constants and month table of the Unix time to calendar converter.
package utcd_pkg;

	localparam int unsigned IN_W  = 32;
	localparam int unsigned OUT_W = 56;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;
	localparam logic [9:0]  DAY_ODD       = 10'd675;
	localparam logic [25:0] DAY_RECIP     = 26'd50903317;
	localparam int unsigned RECIP_SHIFT   = 35;
	localparam logic [8:0]  DAYS_LEAP     = 9'd366;
	localparam logic [8:0]  DAYS_COMMON   = 9'd365;
	localparam logic [11:0] YEAR_BASE     = 12'd1970;
	localparam logic [6:0]  Y100_BASE     = 7'd70;
	localparam logic [8:0]  Y400_BASE     = 9'd370;
	localparam logic [3:0]  MON_FEB       = 4'd1;
	localparam logic [3:0]  MON_MAR       = 4'd2;
	localparam logic [3:0]  MON_NOV       = 4'd10;
	localparam logic [3:0]  MON_DEC       = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_CAL,
		ST_MON,
		ST_FIN
	} utcd_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic setup;
		logic cal;
		logic mon;
	} utcd_cmd_t;

	typedef struct packed {
		logic cal_done;
		logic mon_done;
	} utcd_sts_t;

	typedef struct packed {
		logic        summer_time;
		logic [2:0]  weekday;
		logic [8:0]  day_of_year;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day_of_month;
		logic [3:0]  month_index;
		logic [11:0] year;
	} utcd_res_t;

	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
		logic [4:0] d;
		case (mon)
			4'd1:    d = leap ? 5'd29 : 5'd28;
			4'd3:    d = 5'd30;
			4'd5:    d = 5'd30;
			4'd8:    d = 5'd30;
			4'd10:   d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[src/unix_time_to_calendar_with_dst.sv]
// Top level of the Unix time to calendar converter with US daylight-saving flag.
//
//   channel  dir  beat contents
//   s_axis   in   tdata[31:0] unix_seconds
//   m_axis   out  tdata[55:0] calendar fields, see port comment
//
// One beat in gives one beat out. After the divide by 86400, the year loop runs beside
// the hour and minute countdown, and then the month walk steps on from January. The
// one-year-per-cycle loop is the longest of these phases; the divide by 86400 is a
// reciprocal multiply.
// One timestamp is in work at a time; the output register holds a finished beat
// while the next timestamp is taken. Reset clears control state only.
`include "unix_time_to_calendar_with_dst_macros.svh"
module unix_time_to_calendar_with_dst import utcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // unix_seconds[31:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // year, month_index, day_of_month, hour, minute,
	                                    // second, day_of_year, weekday, summer_time, zero pad
);

	utcd_cmd_t        cmd;
	utcd_sts_t        sts;
	utcd_res_t        res;
	logic             out_load;
	logic             out_free;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	utcd_res_t        m_res;
	logic             out_ranged;
	logic             out_dst_month;

	assign out_free = !m_tvalid_q || m_tready;

	utcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.out_load (out_load),
		.cmd      (cmd)
	);

	utcd_dp u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.in_data (s_tdata),
		.sts     (sts),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{(OUT_W - $bits(utcd_res_t)){1'b0}}, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign m_res         = m_tdata_q[$bits(utcd_res_t)-1:0];
	assign out_ranged    = (m_res.month_index <= MON_DEC) && (m_res.hour <= 5'd23);
	assign out_dst_month = (m_res.month_index >= MON_MAR) && (m_res.month_index <= MON_NOV);

	`UTCD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`UTCD_ASSERT_NOW(a_load_free, clk, arst_n, out_load, !m_tvalid_q || m_tready)
	`UTCD_ASSERT_NOW(a_field_range, clk, arst_n, m_tvalid, out_ranged)
	`UTCD_ASSERT_NOW(a_dst_months, clk, arst_n, m_tvalid && m_res.summer_time, out_dst_month)

endmodule

[src/utcd_ctrl.sv]
// Sequencer for the divide, year/time-of-day, month and output phases.
module utcd_ctrl import utcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	input  utcd_sts_t sts,
	output logic      in_ready,
	output logic      out_load,
	output utcd_cmd_t cmd
);

	utcd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_CAL;
			end
			ST_CAL: begin
				cmd.cal = 1'b1;
				if (sts.cal_done) begin
					state_d = ST_MON;
				end
			end
			ST_MON: begin
				cmd.mon = 1'b1;
				if (sts.mon_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/utcd_dp.sv]
// Datapath: day divider, year and time-of-day reduction, month walk, weekday and DST flag.
module utcd_dp import utcd_pkg::*; (
	input  logic             clk,
	input  utcd_cmd_t        cmd,
	input  logic [IN_W-1:0]  in_data,
	output utcd_sts_t        sts,
	output utcd_res_t        res
);

	logic [31:0] t_q;
	logic [16:0] rem_q;
	logic [2:0]  wmod_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [6:0]  y100_q;
	logic [8:0]  y400_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [3:0]  mon_q;
	logic [8:0]  yday_q;

	logic [50:0] prod;
	logic [9:0]  q_lo;
	logic [9:0]  rday;
	logic [5:0]  oct_sum;
	logic [3:0]  oct_fold;
	logic [2:0]  wmod_next;
	logic        leap;
	logic [8:0]  ylen;
	logic        yr_more, tod_hr, tod_min, mon_more;
	logic [4:0]  dim;
	logic [4:0]  mday;
	logic [3:0]  ws;
	logic [2:0]  wday;
	logic [5:0]  lo;
	logic        late_hour, is_sun, after, equal;

	always_comb begin
		prod      = {26'd0, t_q[31:7]} * {25'd0, DAY_RECIP};
		q_lo      = days_q[9:0] * DAY_ODD;
		rday      = t_q[16:7] - q_lo;
		oct_sum   = {3'd0, days_q[2:0]} + {3'd0, days_q[5:3]} + {3'd0, days_q[8:6]}
			+ {3'd0, days_q[11:9]} + {3'd0, days_q[14:12]} + {5'd0, days_q[15]};
		oct_fold  = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
		wmod_next = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];

		leap     = ((year_q[1:0] == 2'b00) && (y100_q != 7'd0)) || (y400_q == 9'd0);
		ylen     = leap ? DAYS_LEAP : DAYS_COMMON;
		yr_more  = days_q >= {7'd0, ylen};
		tod_hr   = rem_q >= SECS_PER_HOUR;
		tod_min  = rem_q >= SECS_PER_MIN;
		dim      = month_days(mon_q, leap);
		mon_more = (days_q >= {11'd0, dim}) && (mon_q != MON_DEC);

		sts.cal_done = !yr_more && !tod_min;
		sts.mon_done = !mon_more;

		mday = days_q[4:0] + 5'd1;
		ws   = {1'b0, wmod_q} + 4'd4;
		wday = (ws >= 4'd7) ? 3'(ws - 4'd7) : ws[2:0];

		lo        = {1'b0, mday} + 6'd7 - {3'd0, wday};
		late_hour = hour_q >= 5'd2;
		is_sun    = wday == 3'd0;
		after     = 1'b0;
		equal     = 1'b0;
		if (mon_q == MON_MAR) begin
			after = is_sun ? (mday >= 5'd15) : (lo >= 6'd15);
			equal = is_sun && (mday >= 5'd8) && (mday <= 5'd14);
		end else begin
			after = is_sun ? (mday >= 5'd8) : (lo >= 6'd8);
			equal = is_sun && (mday <= 5'd7);
		end

		res.year         = year_q;
		res.month_index  = mon_q;
		res.day_of_month = mday;
		res.hour         = hour_q;
		res.minute       = minute_q;
		res.second       = rem_q[5:0];
		res.day_of_year  = yday_q;
		res.weekday      = wday;
		if ((mon_q < MON_MAR) || (mon_q > MON_NOV)) begin
			res.summer_time = 1'b0;
		end else if ((mon_q > MON_MAR) && (mon_q < MON_NOV)) begin
			res.summer_time = 1'b1;
		end else if (mon_q == MON_MAR) begin
			res.summer_time = after || (equal && late_hour);
		end else begin
			res.summer_time = !(after || (equal && late_hour));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q      <= in_data;
			year_q   <= YEAR_BASE;
			y100_q   <= Y100_BASE;
			y400_q   <= Y400_BASE;
			hour_q   <= '0;
			minute_q <= '0;
			mon_q    <= '0;
		end
		if (cmd.div_step) begin
			days_q <= prod[RECIP_SHIFT+15:RECIP_SHIFT];
		end
		if (cmd.setup) begin
			rem_q  <= {rday, t_q[6:0]};
			wmod_q <= wmod_next;
		end
		if (cmd.cal) begin
			if (yr_more) begin
				days_q <= days_q - {7'd0, ylen};
				year_q <= year_q + 12'd1;
				y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
				y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
			end else begin
				yday_q <= days_q[8:0];
			end
			if (tod_hr) begin
				rem_q  <= rem_q - SECS_PER_HOUR;
				hour_q <= hour_q + 5'd1;
			end else if (tod_min) begin
				rem_q    <= rem_q - SECS_PER_MIN;
				minute_q <= minute_q + 6'd1;
			end
		end
		if (cmd.mon && mon_more) begin
			days_q <= days_q - {11'd0, dim};
			mon_q  <= mon_q + 4'd1;
		end
	end

endmodule

[test/tb_unix_time_to_calendar_with_dst.sv]
// Testbench for the Unix time to calendar converter: directed rows, random timestamps, stalls.
module tb_unix_time_to_calendar_with_dst;
	import utcd_pkg::*;

	localparam int unsigned N_DIR       = 20;
	localparam int unsigned N_RANDOM    = 1600;
	localparam int unsigned STALL_LIMIT = 10000;
	localparam int unsigned RES_W       = $bits(utcd_res_t);
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		logic [31:0] stamp;
		bit          fixed;
		utcd_res_t   want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	utcd_res_t   cal_q [$];
	int unsigned beats_in  = 0;
	int unsigned beats_out = 0;
	int unsigned near_dst  = 0;
	int unsigned errors    = 0;
	int unsigned idle_cnt  = 0;

	stim_row_t dir_rows [N_DIR] = '{
		'{32'd0, 1'b1, utcd_res_t'{summer_time: 1'b0, weekday: 3'd4, day_of_year: 9'd0,
			second: 6'd0, minute: 6'd0, hour: 5'd0, day_of_month: 5'd1, month_index: 4'd0,
			year: 12'd1970}},
		'{32'hFFFF_FFFF, 1'b1, utcd_res_t'{summer_time: 1'b0, weekday: 3'd0,
			day_of_year: 9'd37, second: 6'd15, minute: 6'd28, hour: 5'd6, day_of_month: 5'd7,
			month_index: 4'd1, year: 12'd2106}},
		'{32'd86399, 1'b1, utcd_res_t'{summer_time: 1'b0, weekday: 3'd4, day_of_year: 9'd0,
			second: 6'd59, minute: 6'd59, hour: 5'd23, day_of_month: 5'd1, month_index: 4'd0,
			year: 12'd1970}},
		'{32'd86400,      1'b0, '0},
		'{32'h7FFF_FFFF,  1'b0, '0},
		'{32'h8000_0000,  1'b0, '0},
		'{32'd94694399,   1'b0, '0},
		'{32'd68169600,   1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd978307199,  1'b0, '0},
		'{32'd4107542399, 1'b0, '0},
		'{32'd4107542400, 1'b0, '0},
		'{32'd1710035999, 1'b0, '0},
		'{32'd1710036000, 1'b0, '0},
		'{32'd1730599199, 1'b0, '0},
		'{32'd1730599200, 1'b0, '0},
		'{32'd1709949600, 1'b0, '0},
		'{32'd1730685599, 1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0},
		'{32'h5555_5555,  1'b0, '0}
	};

	unix_time_to_calendar_with_dst i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic bit is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// m is 1..12, result 0 = Sunday
	function automatic logic [2:0] zeller_dow(int unsigned y, int unsigned m, int unsigned d);
		if (m < 3) begin
			m += 12;
			y -= 1;
		end
		return 3'((d + (13 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400 + 6) % 7);
	endfunction

	function automatic int unsigned days_before(int unsigned y);
		int unsigned n;
		n = 0;
		for (int unsigned k = 32'(YEAR_BASE); k < y; k++)
			n += is_leap(k) ? 366 : 365;
		return n;
	endfunction

	function automatic utcd_res_t calendar_of(logic [31:0] stamp);
		int unsigned days, sod, yr, mon, yday, dim, mday, hr, change_day;
		bit          leap;
		utcd_res_t   r;
		sod  = stamp % SECS_PER_DAY;
		days = stamp / SECS_PER_DAY;
		yr   = 32'(YEAR_BASE);
		while (days >= (is_leap(yr) ? 366 : 365)) begin
			days -= is_leap(yr) ? 366 : 365;
			yr++;
		end
		leap = is_leap(yr);
		yday = 0;
		for (mon = 0; mon < 12; mon++) begin
			dim = MONTH_LEN[mon];
			if (mon == MON_FEB && leap)
				dim = 29;
			if (days < dim)
				break;
			yday += dim;
			days -= dim;
		end
		mday = days + 1;
		yday += days;
		hr   = sod / SECS_PER_HOUR;
		r.year         = 12'(yr);
		r.month_index  = 4'(mon);
		r.day_of_month = 5'(mday);
		r.hour         = 5'(hr);
		r.minute       = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
		r.second       = 6'(sod % SECS_PER_MIN);
		r.day_of_year  = 9'(yday);
		r.weekday      = zeller_dow(yr, mon + 1, mday);
		if (mon < MON_MAR || mon > MON_NOV) begin
			r.summer_time = 1'b0;
		end else if (mon > MON_MAR && mon < MON_NOV) begin
			r.summer_time = 1'b1;
		end else if (mon == MON_MAR) begin
			change_day    = (7 - zeller_dow(yr, MON_MAR + 1, 1)) % 7 + 8;
			r.summer_time = (mday > change_day) || (mday == change_day && hr >= 2);
		end else begin
			change_day    = (7 - zeller_dow(yr, MON_NOV + 1, 1)) % 7 + 1;
			r.summer_time = (mday < change_day) || (mday == change_day && hr < 2);
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 40);
		return $urandom_range(41, 300);
	endfunction

	function automatic logic [31:0] pick_stamp();
		int unsigned r, yr, base, sod;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom;
		if (r < 75) begin
			// land near a daylight-saving change day, often right at 02:00
			yr   = $urandom_range(1970, 2105);
			base = days_before(yr) + (is_leap(yr) ? 1 : 0) + ($urandom_range(0, 1) ? 59 : 304)
				+ $urandom_range(0, 13);
			case ($urandom_range(0, 2))
				0: sod = 7199;
				1: sod = 7200;
				default: sod = $urandom_range(0, 14399);
			endcase
			near_dst++;
			return base * SECS_PER_DAY + sod;
		end
		if (r < 88) begin
			yr = $urandom_range(1971, 2106);
			return (days_before(yr) - 1) * SECS_PER_DAY + $urandom_range(0, 2 * 86400 - 1);
		end
		if (r < 94)
			return $urandom_range(0, 400 * 86400);
		return 32'hFFFF_FFFF - $urandom_range(0, 60 * 86400);
	endfunction

	task automatic send_beat(logic [31:0] stamp, int unsigned gap, utcd_res_t want);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= stamp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		cal_q.push_back(want);
		beats_in++;
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	initial begin
		logic [31:0] stamp;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIR; i++)
			send_beat(dir_rows[i].stamp, pick_gap(),
				dir_rows[i].fixed ? dir_rows[i].want : calendar_of(dir_rows[i].stamp));
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 400) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (cal_q.size() != 0) @(posedge clk);
			end
			stamp = pick_stamp();
			send_beat(stamp, (n >= 700 && n < 900) ? 0 : pick_gap(), calendar_of(stamp));
		end
		s_tvalid <= 1'b0;
		while (cal_q.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		$display("%0d timestamps in (%0d directed), %0d calendar beats checked", beats_in,
			N_DIR, beats_out);
		$display("%0d random timestamps placed near daylight-saving change days", near_dst);
		if (errors == 0)
			$display("unix_time_to_calendar_with_dst: match");
		else
			$display("unix_time_to_calendar_with_dst: mismatch");
		$finish;
	end

	initial begin
		int unsigned stall;
		bit          held;
		held = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && beats_out >= 250) begin
				// hold off long enough for the block to back up into its input
				held  = 1'b1;
				stall = 1200;
			end else if (beats_out >= 700 && beats_out < 900) begin
				stall = 0;
			end else begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		utcd_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RES_W-1:0];
			if (cal_q.size() == 0) begin
				$error("calendar beat with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = cal_q.pop_front();
				check_field("year", 32'(want.year), 32'(got.year));
				check_field("month_index", 32'(want.month_index), 32'(got.month_index));
				check_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
				check_field("hour", 32'(want.hour), 32'(got.hour));
				check_field("minute", 32'(want.minute), 32'(got.minute));
				check_field("second", 32'(want.second), 32'(got.second));
				check_field("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
				check_field("weekday", 32'(want.weekday), 32'(got.weekday));
				check_field("summer_time", 32'(want.summer_time), 32'(got.summer_time));
				check_field("pad", 0, 32'(m_tdata[OUT_W-1:RES_W]));
				beats_out++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("no beat moved for %0d cycles, %0d results outstanding", idle_cnt,
					cal_q.size());
				$display("unix_time_to_calendar_with_dst: mismatch");
				$finish;
			end
		end
	end

endmodule

[filelist.f]
+incdir+src
src/utcd_pkg.sv
src/utcd_ctrl.sv
src/utcd_dp.sv
src/unix_time_to_calendar_with_dst.sv
test/tb_unix_time_to_calendar_with_dst.sv
